// ===== hw/rtl/frame_receiver_checksum_check_defines.svh =====
// Assertion macros for the frame receiver checker.
`ifndef FRAME_RECEIVER_CHECKSUM_CHECK_DEFINES_SVH
`define FRAME_RECEIVER_CHECKSUM_CHECK_DEFINES_SVH

// Property checked outside reset.
`define FRMCHK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define FRMCHK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/frmchk_pkg.sv =====
// Package: sizes, register indexes, reset values, state and interface types.
package frmchk_pkg;

  localparam int BUFFER_DEPTH   = 64;
  localparam int ADDR_W         = $clog2(BUFFER_DEPTH);
  localparam int IDX_W          = ADDR_W + 1;
  localparam int BYTE_W         = 8;
  localparam int POS_W          = 6;
  localparam int CNT_W          = 9;   // holds length + 5
  localparam int FRAME_OVERHEAD = 5;
  localparam int CFG_IDX_W      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRAILER0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRAILER1 = 3'd4;

  localparam logic [BYTE_W-1:0] RST_HEADER0  = 8'h43;
  localparam logic [BYTE_W-1:0] RST_HEADER1  = 8'h53;
  localparam logic [BYTE_W-1:0] RST_HEADER2  = 8'h4F;
  localparam logic [BYTE_W-1:0] RST_TRAILER0 = 8'h03;
  localparam logic [BYTE_W-1:0] RST_TRAILER1 = 8'hFF;

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_FRAME,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic hdr_clr;
    logic hdr_inc;
    logic frame_start;
    logic store;
    logic drain_start;
    logic drain_issue;
  } cmd_t;

  typedef struct packed {
    logic hdr_hit;
    logic hdr_last;
    logic store_full;
    logic frame_done;
    logic trailer_ok;
    logic rd_last;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/frame_receiver_checksum_check.sv =====
// Top level of the length-prefixed frame receiver with additive checksum check.
//
// Input channel (in_valid/in_ready/rx_byte): one received byte per item, one item
//   per cycle while hunting for the header or capturing a frame.
// Output channel (out_valid/out_ready): command, length, payload and checksum
//   bytes of a frame with a good trailer, with byte_pos, last on the checksum
//   byte, and checksum_ok for the whole frame on every item.
// Config port (cfg_we/cfg_index/cfg_data): header and trailer bytes, to be
//   written only while idle; the block itself does not enforce this.
// Drain: the first result is registered from the store read that follows
//   the second trailer byte; the store is read one byte a cycle through its
//   registered read port unless out_ready stalls.
// Throughput: one input byte per cycle, except that in_ready is low for the
//   whole drain; a length-L frame is 3 + L + 5 bytes in and L + 3 items out.
// Receiver stalls: a low out_ready holds the current result and pauses the
//   store reads; nothing is lost and input stays stopped until the drain ends.
// Reset (rst, synchronous): back to header hunting, no result pending,
//   registers at their defaults. The store is not cleared; it is always
//   written before it is read within a frame.
module frame_receiver_checksum_check import frmchk_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BYTE_W-1:0]    rx_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BYTE_W-1:0]    frame_byte,
  output logic [POS_W-1:0]     byte_pos,
  output logic                 last,
  output logic                 checksum_ok
);

  cmd_t cmd;   // controller to datapath
  sts_t sts;   // datapath to controller

  // Sequencer: hunt, capture, drain.
  frmchk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  // Storage, compare logic and the output item register.
  frmchk_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .rx_byte     (rx_byte),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .frame_byte  (frame_byte),
    .byte_pos    (byte_pos),
    .last        (last),
    .checksum_ok (checksum_ok)
  );

endmodule

// ===== hw/rtl/frmchk_ram.sv =====
// Generic single-write, single-read RAM with registered, enabled read.
module frmchk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/frmchk_ctrl.sv =====
// Controller: header hunt, frame capture and drain sequencing.
module frmchk_ctrl import frmchk_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  sts_t sts,
  output cmd_t cmd,
  output logic in_ready
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state != ST_DRAIN);
    unique case (state)
      ST_HUNT: begin
        if (in_valid) begin
          if (sts.hdr_hit && sts.hdr_last) begin
            cmd.hdr_clr     = 1'b1;
            cmd.frame_start = 1'b1;
            state_next      = ST_FRAME;
          end else if (sts.hdr_hit) begin
            cmd.hdr_inc = 1'b1;
          end else begin
            cmd.hdr_clr = 1'b1;
          end
        end
      end
      ST_FRAME: begin
        if (in_valid) begin
          if (sts.store_full) begin
            state_next = ST_HUNT;   // overlong frame, byte dropped
          end else begin
            cmd.store = 1'b1;
            if (sts.frame_done && sts.trailer_ok) begin
              cmd.drain_start = 1'b1;
              state_next      = ST_DRAIN;
            end else if (sts.frame_done) begin
              state_next = ST_HUNT;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (sts.out_free) begin
          cmd.drain_issue = 1'b1;
          if (sts.rd_last) begin
            state_next = ST_HUNT;
          end
        end
      end
      default: begin
        state_next = ST_HUNT;
      end
    endcase
  end

endmodule

// ===== hw/rtl/frmchk_dp.sv =====
// Datapath: config registers, header counter, frame store, checksum and output stage.
module frmchk_dp import frmchk_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  input  logic [BYTE_W-1:0]    rx_byte,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [BYTE_W-1:0]    frame_byte,
  output logic [POS_W-1:0]     byte_pos,
  output logic                 last,
  output logic                 checksum_ok
);

  logic [BYTE_W-1:0] header0, header1, header2, trailer0, trailer1;
  logic [1:0]        hdr_cnt;
  logic [IDX_W-1:0]  wr_idx;
  logic [BYTE_W-1:0] plen;
  logic [BYTE_W-1:0] sum;
  logic              sum_ok;
  logic [BYTE_W-1:0] prev_byte;
  logic [ADDR_W-1:0] rd_idx;
  logic [POS_W-1:0]  pos_q;
  logic              last_q;
  logic              ok_q;
  logic [BYTE_W-1:0] hdr_exp;
  logic [CNT_W-1:0]  chk_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      header0  <= RST_HEADER0;
      header1  <= RST_HEADER1;
      header2  <= RST_HEADER2;
      trailer0 <= RST_TRAILER0;
      trailer1 <= RST_TRAILER1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEADER0:  header0  <= cfg_data;
        REG_HEADER1:  header1  <= cfg_data;
        REG_HEADER2:  header2  <= cfg_data;
        REG_TRAILER0: trailer0 <= cfg_data;
        REG_TRAILER1: trailer1 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (hdr_cnt)
      2'd0:    hdr_exp = header0;
      2'd1:    hdr_exp = header1;
      default: hdr_exp = header2;
    endcase
  end

  // checksum sits right after command, length and payload
  assign chk_pos = CNT_W'(plen) + CNT_W'(2);

  assign sts.hdr_hit    = (rx_byte == hdr_exp);
  assign sts.hdr_last   = (hdr_cnt == 2'd2);
  assign sts.store_full = (wr_idx == IDX_W'(BUFFER_DEPTH));
  assign sts.frame_done = ((CNT_W'(wr_idx) + CNT_W'(1)) ==
                           (CNT_W'(plen) + CNT_W'(FRAME_OVERHEAD)));
  assign sts.trailer_ok = (prev_byte == trailer0) && (rx_byte == trailer1);
  assign sts.rd_last    = (CNT_W'(rd_idx) == chk_pos);
  assign sts.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_cnt <= '0;
    end else if (cmd.hdr_clr) begin
      hdr_cnt <= '0;
    end else if (cmd.hdr_inc) begin
      hdr_cnt <= hdr_cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.frame_start) begin
      wr_idx <= '0;
      sum    <= '0;
    end else if (cmd.store) begin
      wr_idx    <= wr_idx + IDX_W'(1);
      sum       <= sum + rx_byte;
      prev_byte <= rx_byte;
      if (wr_idx == IDX_W'(1)) begin
        plen <= rx_byte;
      end
      if (CNT_W'(wr_idx) == chk_pos) begin
        sum_ok <= (sum == rx_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.drain_start) begin
      rd_idx <= '0;
    end else if (cmd.drain_issue) begin
      rd_idx <= rd_idx + ADDR_W'(1);
      pos_q  <= POS_W'(rd_idx);
      last_q <= sts.rd_last;
      ok_q   <= sum_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.drain_issue) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  frmchk_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (wr_idx[ADDR_W-1:0]),
    .wdata (rx_byte),
    .re    (cmd.drain_issue),
    .raddr (rd_idx),
    .rdata (frame_byte)
  );

  assign byte_pos    = pos_q;
  assign last        = last_q;
  assign checksum_ok = ok_q;

endmodule

// ===== hw/rtl/frmchk_checker.sv =====
// Port-level checker for the frame receiver, bound to the top level.
`include "frame_receiver_checksum_check_defines.svh"

module frmchk_checker import frmchk_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic [BYTE_W-1:0] rx_byte,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] frame_byte,
  input logic [POS_W-1:0]  byte_pos,
  input logic              last,
  input logic              checksum_ok
);

  // a stalled item holds its bytes
  `FRMCHK_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(frame_byte) && $stable(byte_pos) && $stable(last) && $stable(checksum_ok), "stalled output item changed")

  // a waiting input item keeps its byte
  `FRMCHK_ASSERT(a_in_hold, in_valid && !in_ready |=> in_valid && $stable(rx_byte), "waiting input item changed")

  // nothing pending straight after reset
  `FRMCHK_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid, "output valid after reset")

  // input is held off until the frame has drained
  `FRMCHK_ASSERT(a_drain_blocks_in, out_valid && !last |-> !in_ready, "input taken mid-drain")

  // a frame has at least command, length and checksum
  `FRMCHK_ASSERT(a_first_not_last, out_valid && byte_pos == '0 |-> !last, "frame shorter than three bytes")

endmodule

bind frame_receiver_checksum_check frmchk_checker u_frmchk_checker (.*);

// ===== sim/frame_receiver_checksum_check_tb.sv =====
// Self-checking testbench for the frame receiver: byte stream in, checked frame bytes out.
module frame_receiver_checksum_check_tb import frmchk_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT   = 200000; // cycles before the watchdog gives up
  localparam int DRAIN_GAP   = 8;      // quiet cycles after the last result of a phase
  localparam int LONG_HOLD   = 300;    // receiver hold-off during the stall phase
  localparam int PHASE_BYTES = 10;     // random bytes queued per phase (roughly)
  localparam int MAX_PLEN    = BUFFER_DEPTH - FRAME_OVERHEAD;

  typedef enum int {
    TRL_GOOD,
    TRL_BAD_FIRST,
    TRL_BAD_SECOND
  } trailer_fault_t;

  // One emitted frame byte as the block should present it
  typedef struct packed {
    logic [BYTE_W-1:0] fbyte;
    logic [POS_W-1:0]  pos;
    logic              last;
    logic              ok;
  } frame_out_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [BYTE_W-1:0]    rx_byte = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [BYTE_W-1:0]    frame_byte;
  logic [POS_W-1:0]     byte_pos;
  logic                 last;
  logic                 checksum_ok;

  // Stimulus side
  logic [BYTE_W-1:0] rx_queue [$];      // bytes waiting to be offered
  logic              in_took = 1'b0;    // item taken at the last rising edge
  int                send_gap_pct = 0;
  int                take_stall_pct = 0;
  int                phase_no = 0;
  logic              long_hold = 1'b0;

  // Predictor state: our own view of the receiver
  logic [BYTE_W-1:0] frame_regs [0:4];
  int                hunt_cnt = 0;
  bit                capturing = 1'b0;
  int                fill = 0;
  logic [BYTE_W-1:0] store_copy [BUFFER_DEPTH];
  frame_out_t        frame_bytes_due [$];

  int unsigned       mismatches = 0;
  int unsigned       cycles = 0;

  frame_receiver_checksum_check dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .frame_byte  (frame_byte),
    .byte_pos    (byte_pos),
    .last        (last),
    .checksum_ok (checksum_ok)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a missing result ends up here
  initial begin : watchdog
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic note_mismatch(input string what, input logic [BYTE_W-1:0] got,
                               input logic [BYTE_W-1:0] want);
    $display("mismatch: %s got %0h want %0h (t=%0t)", what, got, want, $realtime);
    mismatches++;
  endtask

  // Follow one accepted byte through header hunt / capture, queueing any
  // frame bytes it releases.
  task automatic absorb_rx_byte(input logic [BYTE_W-1:0] b);
    int                plen;
    int                n;
    logic [BYTE_W-1:0] sum;
    frame_out_t        r;
    if (!capturing) begin
      // a mismatch drops back to zero without retrying the byte as a start
      if (b == frame_regs[REG_HEADER0 + hunt_cnt]) begin
        hunt_cnt++;
        if (hunt_cnt == 3) begin
          capturing = 1'b1;
          fill = 0;
          hunt_cnt = 0;
        end
      end else begin
        hunt_cnt = 0;
      end
    end else if (fill >= BUFFER_DEPTH) begin
      // store full: frame abandoned, this byte is lost
      capturing = 1'b0;
    end else begin
      store_copy[fill] = b;
      fill++;
      if (fill >= 2) begin
        plen = int'(store_copy[1]);
        if (fill >= plen + FRAME_OVERHEAD) begin
          if (store_copy[fill-2] == frame_regs[REG_TRAILER0] &&
              store_copy[fill-1] == frame_regs[REG_TRAILER1]) begin
            n = plen + 3;
            sum = '0;
            for (int i = 0; i < plen + 2; i++) sum += store_copy[i];
            for (int i = 0; i < n; i++) begin
              r.fbyte = store_copy[i];
              r.pos   = POS_W'(i);
              r.last  = (i == n - 1);
              r.ok    = (sum == store_copy[plen+2]);
              frame_bytes_due.push_back(r);
            end
          end
          // good trailer or not, back to hunting
          capturing = 1'b0;
        end
      end
    end
  endtask

  // Monitor: register writes, accepted bytes and emitted frame bytes, all
  // sampled at the rising edge.
  always @(posedge clk) begin : monitor
    frame_out_t want;
    if (rst) begin
      frame_regs[REG_HEADER0]  = RST_HEADER0;
      frame_regs[REG_HEADER1]  = RST_HEADER1;
      frame_regs[REG_HEADER2]  = RST_HEADER2;
      frame_regs[REG_TRAILER0] = RST_TRAILER0;
      frame_regs[REG_TRAILER1] = RST_TRAILER1;
      hunt_cnt  = 0;
      capturing = 1'b0;
      fill      = 0;
      in_took  <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      // indexes above the last register are ignored by the block
      if (cfg_we && cfg_index <= REG_TRAILER1) frame_regs[cfg_index] = cfg_data;
      if (in_valid && in_ready) absorb_rx_byte(rx_byte);
      if (out_valid && out_ready) begin
        if (frame_bytes_due.size() == 0) begin
          note_mismatch("frame byte with nothing due", frame_byte, '0);
        end else begin
          want = frame_bytes_due.pop_front();
          if (frame_byte !== want.fbyte) note_mismatch("frame_byte", frame_byte, want.fbyte);
          if (byte_pos !== want.pos) note_mismatch("byte_pos", BYTE_W'(byte_pos), BYTE_W'(want.pos));
          if (last !== want.last) note_mismatch("last", BYTE_W'(last), BYTE_W'(want.last));
          if (checksum_ok !== want.ok) begin
            note_mismatch("checksum_ok", BYTE_W'(checksum_ok), BYTE_W'(want.ok));
          end
        end
      end
    end
  end

  // Sender: next byte from the queue, with random gaps; valid holds until taken
  always @(negedge clk) begin : sender
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (rx_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        rx_byte  <= rx_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus the long hold-off when it is active
  always @(negedge clk) begin : receiver
    out_ready <= !rst && !long_hold && ($urandom_range(99) >= take_stall_pct);
  end

  // Long hold-off: starts on the first result of the stall phase, so a frame
  // is mid-drain and the input side backs up behind it.
  initial begin : hold_off
    while (phase_no != 3 || !out_valid) @(posedge clk);
    long_hold = 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    long_hold = 1'b0;
  end

  task automatic queue_header();
    rx_queue.push_back(frame_regs[REG_HEADER0]);
    rx_queue.push_back(frame_regs[REG_HEADER1]);
    rx_queue.push_back(frame_regs[REG_HEADER2]);
  endtask

  // Whole frame with the current header/trailer; checksum and trailer may be spoilt
  task automatic queue_frame(input int plen, input logic [BYTE_W-1:0] cmd,
                             input bit bad_sum, input trailer_fault_t fault);
    logic [BYTE_W-1:0] body [$];
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] t0;
    logic [BYTE_W-1:0] t1;
    body.push_back(cmd);
    body.push_back(BYTE_W'(plen));
    for (int i = 0; i < plen; i++) body.push_back(BYTE_W'($urandom));
    sum = '0;
    foreach (body[i]) sum += body[i];
    if (bad_sum) sum ^= BYTE_W'($urandom_range(1, 255));
    t0 = frame_regs[REG_TRAILER0];
    t1 = frame_regs[REG_TRAILER1];
    if (fault == TRL_BAD_FIRST) t0 ^= BYTE_W'($urandom_range(1, 255));
    if (fault == TRL_BAD_SECOND) t1 ^= BYTE_W'($urandom_range(1, 255));
    queue_header();
    foreach (body[i]) rx_queue.push_back(body[i]);
    rx_queue.push_back(sum);
    rx_queue.push_back(t0);
    rx_queue.push_back(t1);
  endtask

  // Length too big for the store: fills it, then one byte that gets dropped
  task automatic queue_overrun();
    queue_header();
    rx_queue.push_back(BYTE_W'($urandom));
    rx_queue.push_back(BYTE_W'($urandom_range(MAX_PLEN + 1, 255)));
    repeat (BUFFER_DEPTH - 2 + 1) rx_queue.push_back(BYTE_W'($urandom));
  endtask

  task automatic add_random_sequence();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      queue_frame($urandom_range(0, 8), BYTE_W'($urandom), 1'b0, TRL_GOOD);
    end else if (pick < 65) begin
      queue_frame($urandom_range(0, 8), BYTE_W'($urandom), 1'b1, TRL_GOOD);
    end else if (pick < 72) begin
      queue_frame($urandom_range(0, 6), BYTE_W'($urandom), 1'b0, TRL_BAD_FIRST);
    end else if (pick < 79) begin
      queue_frame($urandom_range(0, 6), BYTE_W'($urandom), 1'b0, TRL_BAD_SECOND);
    end else if (pick < 87) begin
      // stray first header byte just ahead of a real frame
      rx_queue.push_back(frame_regs[REG_HEADER0]);
      queue_frame($urandom_range(0, 6), BYTE_W'($urandom), 1'b0, TRL_GOOD);
    end else if (pick < 93) begin
      // header cut short: third byte never matches
      rx_queue.push_back(frame_regs[REG_HEADER0]);
      rx_queue.push_back(frame_regs[REG_HEADER1]);
      rx_queue.push_back(frame_regs[REG_HEADER2] ^ BYTE_W'($urandom_range(1, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) rx_queue.push_back(BYTE_W'($urandom));
    end
  endtask

  task automatic random_phase();
    // open with a clean frame so every phase drains something
    queue_frame($urandom_range(1, 8), BYTE_W'($urandom), 1'b0, TRL_GOOD);
    while (rx_queue.size() < PHASE_BYTES) add_random_sequence();
  endtask

  // Wait until the sender is empty and every due byte has come out
  task automatic settle();
    while (rx_queue.size() != 0 || in_valid || frame_bytes_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // Register writes, one per cycle, plus one write to an unused index
  task automatic load_regs(input logic [BYTE_W-1:0] h0, input logic [BYTE_W-1:0] h1,
                           input logic [BYTE_W-1:0] h2, input logic [BYTE_W-1:0] t0,
                           input logic [BYTE_W-1:0] t1);
    logic [CFG_IDX_W-1:0] idx [5];
    logic [BYTE_W-1:0]    val [5];
    idx = '{REG_HEADER0, REG_HEADER1, REG_HEADER2, REG_TRAILER0, REG_TRAILER1};
    val = '{h0, h1, h2, t0, t1};
    for (int i = 0; i < 5; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
    end
    @(negedge clk);
    cfg_index <= REG_TRAILER1 + CFG_IDX_W'($urandom_range(1, 3));
    cfg_data  <= BYTE_W'($urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed: reset header/trailer, no idling
    // repeated first header byte: the repeat must not count as a new start
    rx_queue.push_back(RST_HEADER0);
    rx_queue.push_back(RST_HEADER0);
    rx_queue.push_back(RST_HEADER1);
    queue_frame(0, 8'h00, 1'b0, TRL_GOOD);        // empty payload
    queue_frame(1, 8'hFF, 1'b0, TRL_GOOD);
    queue_frame(2, 8'h81, 1'b1, TRL_GOOD);        // checksum wrong, still emitted
    queue_frame(0, 8'h5A, 1'b0, TRL_BAD_SECOND);  // silently dropped
    settle();

    // All-zero header and trailer, no idling
    load_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    phase_no = 1;
    random_phase();
    settle();

    // All-ones, sender gaps
    load_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    phase_no = 2;
    send_gap_pct = 56;
    random_phase();
    settle();

    // Random header/trailer, receiver stalls and the long hold-off
    load_regs(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
              BYTE_W'($urandom), BYTE_W'($urandom));
    phase_no = 3;
    send_gap_pct = 0;
    take_stall_pct = 56;
    random_phase();
    settle();

    // Back to the defaults, light gaps on both sides; one store overrun
    load_regs(RST_HEADER0, RST_HEADER1, RST_HEADER2, RST_TRAILER0, RST_TRAILER1);
    phase_no = 4;
    send_gap_pct = 20;
    take_stall_pct = 20;
    random_phase();
    queue_overrun();
    queue_frame($urandom_range(0, 8), BYTE_W'($urandom), 1'b0, TRL_GOOD);
    settle();

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
